/* hdl/wrsd_pkg.sv */
// Package for the write request slot dispatcher.
// Holds the sequencer state type, status and kind codes and the byte mask helper.
// No dependencies.
`default_nettype none

package wrsd_pkg;

    typedef logic [1:0] t_status;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_BAD_RANGE = 2'd1;
    localparam t_status ST_TOO_LONG  = 2'd2;
    localparam t_status ST_NO_SLOT   = 2'd3;

    localparam logic KIND_WRITE    = 1'b0;
    localparam logic KIND_COMPLETE = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_FIND,
        S_DISPATCH,
        S_SCAN,
        S_FETCH,
        S_RESULT
    } t_state;

    function automatic logic [63:0] byte_mask(input logic [3:0] n);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            m[8*i +: 8] = (n > 4'(i)) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

endpackage

`default_nettype wire

/* hdl/write_request_slot_dispatcher.sv */
// Write request slot dispatcher: slot store, scan sequencer and output register.
// A completion, or a write request that passes the checks and finds a slot, issues the lowest
// occupied slot, if any, when the sink is idle; otherwise the result carries no issue.
// A single compare steps through one slot per cycle in each scan.
// A new input can be taken in the cycle after the result has moved into the output register.
// Synchronous active-low reset clears occupancy and active-slot state and idles the sink.
`default_nettype none

module write_request_slot_dispatcher #(
    parameter int SLOT_COUNT   = 8,
    parameter int MAX_BYTES    = 8,
    parameter int MEMORY_BYTES = 32768
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire logic             i_kind,
    input  wire logic [14:0]      i_address,
    input  wire logic [3:0]       i_length,
    input  wire logic [63:0]      i_payload,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output wrsd_pkg::t_status     o_status,
    output logic                  o_issue_valid,
    output logic [14:0]           o_issue_address,
    output logic [3:0]            o_issue_length,
    output logic [63:0]           o_issue_payload
);
    import wrsd_pkg::*;

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

    t_state r_state, n_state;

    logic [SLOT_COUNT-1:0] r_occ;
    logic                  r_sink_idle;
    logic                  r_active_present;
    logic [IDX_W-1:0]      r_active_idx;
    logic [IDX_W-1:0]      r_idx;

    logic [14:0] r_address;
    logic [3:0]  r_length;
    logic [63:0] r_payload;

    t_status r_status, n_status;
    logic    r_iss_valid, n_iss_valid;

    logic [14:0] mem_addr [SLOT_COUNT];
    logic [3:0]  mem_len  [SLOT_COUNT];
    logic [63:0] mem_data [SLOT_COUNT];
    logic [14:0] r_rd_addr;
    logic [3:0]  r_rd_len;
    logic [63:0] r_rd_data;

    logic load_item, idx_clr, idx_inc, store_en, clear_active, rd_en, load_out;
    logic bad_range, too_long;

    assign bad_range = (r_length == 4'd0) ||
                       ((17'(r_address) + 17'(r_length)) >= 17'(MEMORY_BYTES));
    assign too_long  = (r_length > 4'(MAX_BYTES));

    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_status     = r_status;
        n_iss_valid  = r_iss_valid;
        load_item    = 1'b0;
        idx_clr      = 1'b0;
        idx_inc      = 1'b0;
        store_en     = 1'b0;
        clear_active = 1'b0;
        rd_en        = 1'b0;
        load_out     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    load_item   = 1'b1;
                    n_status    = ST_OK;
                    n_iss_valid = 1'b0;
                    n_state     = (i_kind == KIND_COMPLETE) ? S_DISPATCH : S_CHECK;
                end
            end
            S_CHECK: begin
                idx_clr = 1'b1;
                if (bad_range) begin
                    n_status = ST_BAD_RANGE;
                    n_state  = S_RESULT;
                end else if (too_long) begin
                    n_status = ST_TOO_LONG;
                    n_state  = S_RESULT;
                end else begin
                    n_state = S_FIND;
                end
            end
            S_FIND: begin
                if (!r_occ[r_idx]) begin
                    store_en = 1'b1;
                    n_state  = S_DISPATCH;
                end else if (r_idx == LAST_IDX) begin
                    n_status = ST_NO_SLOT;
                    n_state  = S_RESULT;
                end else begin
                    idx_inc = 1'b1;
                end
            end
            S_DISPATCH: begin
                idx_clr = 1'b1;
                if (r_sink_idle) begin
                    clear_active = 1'b1;
                    n_state      = S_SCAN;
                end else begin
                    n_state = S_RESULT;
                end
            end
            S_SCAN: begin
                if (r_occ[r_idx]) begin
                    rd_en       = 1'b1;
                    n_iss_valid = 1'b1;
                    n_state     = S_FETCH;
                end else if (r_idx == LAST_IDX) begin
                    n_state = S_RESULT;
                end else begin
                    idx_inc = 1'b1;
                end
            end
            S_FETCH: begin
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (o_out_valid && i_out_stall) begin
                    n_state = S_RESULT;
                end else begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ            <= '0;
            r_sink_idle      <= 1'b1;
            r_active_present <= 1'b0;
            r_active_idx     <= '0;
            o_out_valid      <= 1'b0;
        end else begin
            if (load_item && i_kind == KIND_COMPLETE) begin
                r_sink_idle <= 1'b1;
            end
            if (store_en) begin
                r_occ[r_idx] <= 1'b1;
            end
            if (clear_active) begin
                r_active_present <= 1'b0;
                if (r_active_present) begin
                    r_occ[r_active_idx] <= 1'b0;
                end
            end
            if (rd_en) begin
                r_active_present <= 1'b1;
                r_active_idx     <= r_idx;
                r_sink_idle      <= 1'b0;
            end
            if (load_out) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_status    <= n_status;
        r_iss_valid <= n_iss_valid;
        if (load_item) begin
            r_address <= i_address;
            r_length  <= i_length;
            r_payload <= i_payload;
        end
        if (idx_clr) begin
            r_idx <= '0;
        end else if (idx_inc) begin
            r_idx <= r_idx + 1'b1;
        end
        if (load_out) begin
            o_status        <= r_status;
            o_issue_valid   <= r_iss_valid;
            o_issue_address <= r_iss_valid ? r_rd_addr : 15'd0;
            o_issue_length  <= r_iss_valid ? r_rd_len : 4'd0;
            o_issue_payload <= r_iss_valid ? r_rd_data : 64'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (store_en) begin
            mem_addr[r_idx] <= r_address;
            mem_len[r_idx]  <= r_length;
            mem_data[r_idx] <= r_payload & byte_mask(r_length);
        end
        if (rd_en) begin
            r_rd_addr <= mem_addr[r_idx];
            r_rd_len  <= mem_len[r_idx];
            r_rd_data <= mem_data[r_idx];
        end
    end

endmodule

`default_nettype wire

/* hdl/wrsd_checker.sv */
// Port-level checker for the write request slot dispatcher, bound to the top level.
// Depends on wrsd_pkg for the status codes.
`default_nettype none

module wrsd_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              o_in_stall,
    input wire logic              o_out_valid,
    input wire logic              i_out_stall,
    input wire wrsd_pkg::t_status o_status,
    input wire logic              o_issue_valid,
    input wire logic [14:0]       o_issue_address,
    input wire logic [3:0]        o_issue_length,
    input wire logic [63:0]       o_issue_payload
);
    import wrsd_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("Stalled result was dropped.");

    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("Input was not held off while a transfer is processed.");

    a_no_issue_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_issue_valid |->
            o_issue_address == 15'd0 && o_issue_length == 4'd0 && o_issue_payload == 64'd0)
        else $error("Issue fields are not zero without an issue.");

    a_issue_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_issue_valid |-> o_status == ST_OK && o_issue_length != 4'd0)
        else $error("Issue with a failing status or empty length.");

endmodule

bind write_request_slot_dispatcher wrsd_checker u_wrsd_checker (.*);

`default_nettype wire

/* tb/tb_write_request_slot_dispatcher.sv */
// Self-checking testbench for the write request slot dispatcher.
// Drives write requests and completion events with random gaps and stalls, and checks each result.
// Depends on wrsd_pkg and write_request_slot_dispatcher.
`default_nettype none

module tb_write_request_slot_dispatcher;
    import wrsd_pkg::*;

    localparam int SLOT_N       = 8;
    localparam int MAX_LEN      = 8;
    localparam int MEM_BYTES    = 32768;
    localparam int TOTAL_ITEMS  = 1450;
    localparam int DRAIN_CYCLES = 100;

    typedef struct packed {
        logic        kind;
        logic [14:0] address;
        logic [3:0]  length;
        logic [63:0] payload;
        logic [3:0]  gap;
    } t_request;

    typedef struct packed {
        t_status     status;
        logic        issue_valid;
        logic [14:0] issue_address;
        logic [3:0]  issue_length;
        logic [63:0] issue_payload;
    } t_write_result;

    logic        clk;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_kind     = KIND_WRITE;
    logic [14:0] in_address  = '0;
    logic [3:0]  in_length   = '0;
    logic [63:0] in_payload  = '0;
    logic        out_stall   = 1'b0;
    logic        in_stall;
    logic        out_valid;
    t_status     out_status;
    logic        out_issue_valid;
    logic [14:0] out_issue_address;
    logic [3:0]  out_issue_length;
    logic [63:0] out_issue_payload;

    t_request      pending_requests[$];
    t_write_result expected_results[$];
    t_request      active_req = '0;
    logic [3:0]    gap_left   = '0;
    int unsigned   stall_left = 0;
    int unsigned   cycle_q    = 0;
    logic          hold_on    = 1'b0;

    int queued         = 0;
    int n_sent         = 0;
    int n_issued       = 0;
    int n_rejected     = 0;
    int n_full         = 0;
    int n_errors       = 0;

    logic [3:0]  slot_len_m  [SLOT_N];
    logic [14:0] slot_addr_m [SLOT_N];
    logic [63:0] slot_data_m [SLOT_N];
    logic        sink_free_m;
    logic        active_valid_m;
    logic [2:0]  active_slot_m;

    write_request_slot_dispatcher #(
        .SLOT_COUNT   (SLOT_N),
        .MAX_BYTES    (MAX_LEN),
        .MEMORY_BYTES (MEM_BYTES)
    ) uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_kind          (in_kind),
        .i_address       (in_address),
        .i_length        (in_length),
        .i_payload       (in_payload),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_status        (out_status),
        .o_issue_valid   (out_issue_valid),
        .o_issue_address (out_issue_address),
        .o_issue_length  (out_issue_length),
        .o_issue_payload (out_issue_payload)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] keep_bytes(input logic [63:0] data, input logic [3:0] n);
        if (n >= 4'd8) begin
            return data;
        end
        return data & ((64'd1 << (8 * n)) - 64'd1);
    endfunction

    function automatic t_write_result issue_lowest_slot();
        t_write_result r;
        logic          found;
        r = '0;
        found = 1'b0;
        if (sink_free_m) begin
            if (active_valid_m) begin
                slot_len_m[active_slot_m] = '0;
            end
            active_valid_m = 1'b0;
            for (int i = 0; i < SLOT_N; i++) begin
                if (!found && slot_len_m[i] != '0) begin
                    found = 1'b1;
                    active_valid_m = 1'b1;
                    active_slot_m = 3'(i);
                    sink_free_m = 1'b0;
                    r.issue_valid = 1'b1;
                    r.issue_address = slot_addr_m[i];
                    r.issue_length = slot_len_m[i];
                    r.issue_payload = keep_bytes(slot_data_m[i], slot_len_m[i]);
                end
            end
        end
        return r;
    endfunction

    function automatic t_write_result predict_write_result(input t_request req);
        t_write_result r;
        int            span;
        int            free_slot;
        r = '0;
        span = req.address + req.length;
        free_slot = -1;
        if (req.kind == KIND_COMPLETE) begin
            sink_free_m = 1'b1;
            r = issue_lowest_slot();
            r.status = ST_OK;
        end else if (req.length == '0 || span >= MEM_BYTES) begin
            r.status = ST_BAD_RANGE;
        end else if (req.length > MAX_LEN) begin
            r.status = ST_TOO_LONG;
        end else begin
            for (int i = SLOT_N - 1; i >= 0; i--) begin
                if (slot_len_m[i] == '0) begin
                    free_slot = i;
                end
            end
            if (free_slot < 0) begin
                r.status = ST_NO_SLOT;
            end else begin
                slot_len_m[free_slot] = req.length;
                slot_addr_m[free_slot] = req.address;
                slot_data_m[free_slot] = keep_bytes(req.payload, req.length);
                r = issue_lowest_slot();
                r.status = ST_OK;
            end
        end
        return r;
    endfunction

    task automatic queue_request(input logic kind, input logic [14:0] addr,
                                 input logic [3:0] len, input logic [63:0] data);
        t_request r;
        r.kind = kind;
        r.address = addr;
        r.length = len;
        r.payload = data;
        r.gap = ((queued % 300) < 40) ? 4'd0 : 4'($urandom_range(0, 9));
        pending_requests.push_back(r);
        queued++;
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
        n_errors++;
    endtask

    always @(posedge clk) begin : p_drive
        logic     busy;
        t_request next_req;
        if (!rst_n) begin
            in_valid <= 1'b0;
            gap_left <= '0;
        end else begin
            busy = in_valid;
            if (in_valid && !in_stall) begin
                expected_results.push_back(predict_write_result(active_req));
                n_sent++;
                busy = 1'b0;
            end
            if (!busy) begin
                if (gap_left != '0) begin
                    gap_left <= gap_left - 4'd1;
                    in_valid <= 1'b0;
                end else if (pending_requests.size() != 0) begin
                    next_req = pending_requests.pop_front();
                    active_req <= next_req;
                    in_kind <= next_req.kind;
                    in_address <= next_req.address;
                    in_length <= next_req.length;
                    in_payload <= next_req.payload;
                    gap_left <= next_req.gap;
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // The long hold-offs let the result register fill so that the input side stalls.
    always @(posedge clk) begin
        if (!rst_n) begin
            cycle_q <= 0;
            hold_on <= 1'b0;
        end else begin
            cycle_q <= cycle_q + 1;
            hold_on <= (cycle_q >= 3000 && cycle_q < 3800) ||
                       (cycle_q >= 25000 && cycle_q < 25600);
        end
    end

    always @(posedge clk) begin : p_sink
        int unsigned   wait_next;
        t_write_result want;
        if (!rst_n) begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end else begin
            wait_next = stall_left;
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with nothing expected", 64'(out_status), 64'd0);
                end else begin
                    want = expected_results.pop_front();
                    if (out_status !== want.status)
                        report_mismatch("status", 64'(out_status), 64'(want.status));
                    if (out_issue_valid !== want.issue_valid)
                        report_mismatch("issue_valid", 64'(out_issue_valid),
                                        64'(want.issue_valid));
                    if (out_issue_address !== want.issue_address)
                        report_mismatch("issue_address", 64'(out_issue_address),
                                        64'(want.issue_address));
                    if (out_issue_length !== want.issue_length)
                        report_mismatch("issue_length", 64'(out_issue_length),
                                        64'(want.issue_length));
                    if (out_issue_payload !== want.issue_payload)
                        report_mismatch("issue_payload", out_issue_payload,
                                        want.issue_payload);
                    if (want.issue_valid)
                        n_issued++;
                    if (want.status == ST_NO_SLOT)
                        n_full++;
                    if (want.status == ST_BAD_RANGE || want.status == ST_TOO_LONG)
                        n_rejected++;
                end
                wait_next = ((cycle_q % 4096) >= 3500) ? 0 : $urandom_range(0, 9);
            end else if (wait_next != 0) begin
                wait_next = wait_next - 1;
            end
            stall_left <= wait_next;
            out_stall <= hold_on || (wait_next != 0);
        end
    end

    initial begin : p_main
        int          choice;
        logic [3:0]  len;
        logic [63:0] ones;
        ones = '1;
        for (int i = 0; i < SLOT_N; i++) begin
            slot_len_m[i] = '0;
            slot_addr_m[i] = '0;
            slot_data_m[i] = '0;
        end
        sink_free_m = 1'b1;
        active_valid_m = 1'b0;
        active_slot_m = '0;

        queue_request(KIND_COMPLETE, 15'h7FFF, 4'hF, ones);
        queue_request(KIND_WRITE, 15'd0, 4'd0, ones);
        queue_request(KIND_WRITE, 15'd32767, 4'd1, ones);
        queue_request(KIND_WRITE, 15'd32760, 4'd8, ones);
        queue_request(KIND_WRITE, 15'd0, 4'd9, ones);
        queue_request(KIND_WRITE, 15'd0, 4'd15, ones);
        queue_request(KIND_WRITE, 15'd32767, 4'd15, ones);
        queue_request(KIND_WRITE, 15'd0, 4'd1, ones);
        queue_request(KIND_WRITE, 15'd32759, 4'd8, ones);
        for (int i = 2; i <= 7; i++) begin
            queue_request(KIND_WRITE, 15'($urandom_range(0, 30000)), 4'(i),
                          {$urandom, $urandom});
        end
        queue_request(KIND_WRITE, 15'h2AAA, 4'd3, ones);
        queue_request(KIND_COMPLETE, 15'd0, 4'd0, 64'd0);
        queue_request(KIND_WRITE, 15'd100, 4'd4, {$urandom, $urandom});
        for (int i = 0; i < 9; i++) begin
            queue_request(KIND_COMPLETE, 15'($urandom), 4'($urandom), {$urandom, $urandom});
        end

        // Mostly bursts of legal writes followed by completions, with some malformed items.
        while (queued < TOTAL_ITEMS) begin
            choice = $urandom_range(0, 9);
            if (choice < 8) begin
                repeat ($urandom_range(1, 10)) begin
                    len = 4'($urandom_range(1, MAX_LEN));
                    queue_request(KIND_WRITE, 15'($urandom_range(0, MEM_BYTES - 1 - len)), len,
                                  {$urandom, $urandom});
                end
                repeat ($urandom_range(1, 8)) begin
                    queue_request(KIND_COMPLETE, 15'($urandom), 4'($urandom),
                                  {$urandom, $urandom});
                end
            end else begin
                queue_request(1'($urandom_range(0, 1)), 15'($urandom), 4'($urandom),
                              {$urandom, $urandom});
            end
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_requests.size() != 0 || in_valid) @(posedge clk);
        while (expected_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d transfers in: %0d writes issued, %0d range or length rejects,",
                 n_sent, n_issued, n_rejected);
        $display("and %0d requests turned away with every slot taken.", n_full);
        if (n_errors == 0 && expected_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
hdl/wrsd_pkg.sv
hdl/write_request_slot_dispatcher.sv
hdl/wrsd_checker.sv
tb/tb_write_request_slot_dispatcher.sv
